@@ hdl/mvt_pkg.sv @@
// shared types, constants and helpers for the 4x4 matrix vertex transform
// no dependencies; used by every module in hdl/
package mvt_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int DIM        = 4;
	localparam int ELEMS      = 16;
	localparam int TRANS_BASE = 3 * 4;
	localparam int WORD_W     = 32;
	localparam int IDX_W      = $clog2(ELEMS);
	localparam int PROD_W     = 2 * WORD_W - FRAC_BITS;
	localparam int SUM_W      = PROD_W + $clog2(DIM);

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [SUM_W-1:0]  sum_t;

	// 1.0 in the fixed-point format
	localparam word_t ONE = word_t'(1) <<< FRAC_BITS;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_SCALE = 2'd1,
		OP_VEC4  = 2'd2,
		OP_POINT = 2'd3
	} op_t;

	typedef struct packed {
		word_t value;
		logic  sat;
	} clamp_t;

	// clamp a wide sum to the signed word range
	function automatic clamp_t clamp_word(input sum_t s);
		clamp_t r;
		r.sat = (s[SUM_W-1:WORD_W-1] != {(SUM_W-WORD_W+1){1'b0}}) &&
			(s[SUM_W-1:WORD_W-1] != {(SUM_W-WORD_W+1){1'b1}});
		if (r.sat) begin
			r.value = s[SUM_W-1] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
		end else begin
			r.value = s[WORD_W-1:0];
		end
		return r;
	endfunction

endpackage

@@ hdl/mvt_prod_stage.sv @@
// sixteen element-by-operand multipliers with the registered product bank
// depends on mvt_pkg
module mvt_prod_stage (
	input  logic              clk,
	input  logic              en,
	input  mvt_pkg::op_t      op,
	input  mvt_pkg::word_t    load_value,
	input  mvt_pkg::word_t    in_x,
	input  mvt_pkg::word_t    in_y,
	input  mvt_pkg::word_t    in_z,
	input  mvt_pkg::word_t    in_w,
	input  mvt_pkg::word_t    matrix [mvt_pkg::ELEMS],
	output mvt_pkg::prod_t    prod_s2 [mvt_pkg::ELEMS]
);

	mvt_pkg::word_t col_opnd [mvt_pkg::DIM];

	// point mode multiplies the translation column by one, which adds it exactly
	always_comb begin
		if (op == mvt_pkg::OP_SCALE) begin
			for (int c = 0; c < mvt_pkg::DIM; c++) col_opnd[c] = load_value;
		end else begin
			col_opnd[0] = in_x;
			col_opnd[1] = in_y;
			col_opnd[2] = in_z;
			col_opnd[3] = (op == mvt_pkg::OP_POINT) ? mvt_pkg::ONE : in_w;
		end
	end

	for (genvar g = 0; g < mvt_pkg::ELEMS; g++) begin : g_lane
		localparam int COL = g / mvt_pkg::DIM;
		logic signed [2*mvt_pkg::WORD_W-1:0] full;

		assign full = $signed(matrix[g]) * $signed(col_opnd[COL]);

		// arithmetic shift right is the upper part of the product
		always_ff @(posedge clk) begin
			if (en) begin
				prod_s2[g] <= full[2*mvt_pkg::WORD_W-1:mvt_pkg::FRAC_BITS];
			end
		end
	end

endmodule

@@ hdl/mvt_clamp_stage.sv @@
// row sums with saturation, and per-element clamp for the scale update
// depends on mvt_pkg
module mvt_clamp_stage (
	input  mvt_pkg::prod_t  prod [mvt_pkg::ELEMS],
	output mvt_pkg::word_t  row_sum [mvt_pkg::DIM],
	output logic [mvt_pkg::DIM-1:0] row_sat,
	output mvt_pkg::word_t  scaled [mvt_pkg::ELEMS]
);

	always_comb begin
		mvt_pkg::sum_t   acc;
		mvt_pkg::clamp_t cl;
		for (int r = 0; r < mvt_pkg::DIM; r++) begin
			acc = '0;
			for (int c = 0; c < mvt_pkg::DIM; c++) begin
				acc = acc + mvt_pkg::sum_t'(prod[r + c * mvt_pkg::DIM]);
			end
			cl = mvt_pkg::clamp_word(acc);
			row_sum[r] = cl.value;
			row_sat[r] = cl.sat;
		end
	end

	always_comb begin
		mvt_pkg::clamp_t ce;
		for (int e = 0; e < mvt_pkg::ELEMS; e++) begin
			ce = mvt_pkg::clamp_word(mvt_pkg::sum_t'(prod[e]));
			scaled[e] = ce.value;
		end
	end

endmodule

@@ hdl/matrix4_vertex_transform.sv @@
// matrix4_vertex_transform: 4x4 Q16.16 matrix held in registers, column-major
// result path: input register, then product register, then result register
// one item per cycle for every opcode unless stalled; set by the 16 parallel multipliers
// load and scale give no result; a scale is forwarded to the item right behind it
// reset (arst_n low, asynchronous) clears the matrix to zero and empties the pipeline
// depends on mvt_pkg, mvt_prod_stage, mvt_clamp_stage
module matrix4_vertex_transform (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_stall,
	input  logic [1:0]     opcode,
	input  logic [3:0]     elem_index,
	input  logic signed [31:0] load_value,
	input  logic signed [31:0] in_x,
	input  logic signed [31:0] in_y,
	input  logic signed [31:0] in_z,
	input  logic signed [31:0] in_w,
	output logic           result_valid,
	input  logic           result_stall,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [31:0] out_z,
	output logic signed [31:0] out_w,
	output logic           saturated
);

	logic                        valid_s1;
	mvt_pkg::op_t                op_s1;
	logic [mvt_pkg::IDX_W-1:0]   idx_s1;
	mvt_pkg::word_t              value_s1;
	mvt_pkg::word_t              x_s1, y_s1, z_s1, w_s1;

	logic                        valid_s2;
	mvt_pkg::op_t                op_s2;

	logic                        result_valid_q;
	mvt_pkg::word_t              out_x_q, out_y_q, out_z_q, out_w_q;
	logic                        saturated_q;

	mvt_pkg::word_t              matrix_q   [mvt_pkg::ELEMS];
	mvt_pkg::word_t              matrix_eff [mvt_pkg::ELEMS];
	mvt_pkg::prod_t              prod_s2    [mvt_pkg::ELEMS];
	mvt_pkg::word_t              scaled     [mvt_pkg::ELEMS];
	mvt_pkg::word_t              row_sum    [mvt_pkg::DIM];
	logic [mvt_pkg::DIM-1:0]     row_sat;

	logic res_s2, scale_s2, load_s1, out_free, s2_adv, s1_adv;

	assign res_s2   = valid_s2 && (op_s2 == mvt_pkg::OP_VEC4 || op_s2 == mvt_pkg::OP_POINT);
	assign scale_s2 = valid_s2 && (op_s2 == mvt_pkg::OP_SCALE);
	assign out_free = !result_valid_q || !result_stall;
	assign s2_adv   = !res_s2 || out_free;
	assign s1_adv   = !valid_s1 || s2_adv;
	assign load_s1  = valid_s1 && (op_s1 == mvt_pkg::OP_LOAD) && s2_adv;

	assign item_stall = !s1_adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_adv) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			op_s1    <= mvt_pkg::op_t'(opcode);
			idx_s1   <= elem_index;
			value_s1 <= load_value;
			x_s1     <= in_x;
			y_s1     <= in_y;
			z_s1     <= in_z;
			w_s1     <= in_w;
		end
	end

	// product stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			op_s2    <= mvt_pkg::OP_LOAD;
		end else if (s2_adv) begin
			valid_s2 <= valid_s1;
			op_s2    <= op_s1;
		end
	end

	// a scale in flight has not reached matrix_q yet, so hand its result forward
	always_comb begin
		for (int e = 0; e < mvt_pkg::ELEMS; e++) begin
			matrix_eff[e] = scale_s2 ? scaled[e] : matrix_q[e];
		end
	end

	// load in stage one is younger than a scale in stage two and wins its element
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int e = 0; e < mvt_pkg::ELEMS; e++) matrix_q[e] <= '0;
		end else begin
			for (int e = 0; e < mvt_pkg::ELEMS; e++) begin
				if (load_s1 && idx_s1 == mvt_pkg::IDX_W'(e)) begin
					matrix_q[e] <= value_s1;
				end else if (scale_s2) begin
					matrix_q[e] <= scaled[e];
				end
			end
		end
	end

	mvt_prod_stage u_prod (
		.clk        (clk),
		.en         (s2_adv),
		.op         (op_s1),
		.load_value (value_s1),
		.in_x       (x_s1),
		.in_y       (y_s1),
		.in_z       (z_s1),
		.in_w       (w_s1),
		.matrix     (matrix_eff),
		.prod_s2    (prod_s2)
	);

	mvt_clamp_stage u_clamp (
		.prod    (prod_s2),
		.row_sum (row_sum),
		.row_sat (row_sat),
		.scaled  (scaled)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_free) begin
			result_valid_q <= res_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && res_s2) begin
			out_x_q <= row_sum[0];
			out_y_q <= row_sum[1];
			out_z_q <= row_sum[2];
			if (op_s2 == mvt_pkg::OP_POINT) begin
				out_w_q     <= '0;
				saturated_q <= |row_sat[2:0];
			end else begin
				out_w_q     <= row_sum[3];
				saturated_q <= |row_sat;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign out_x        = out_x_q;
	assign out_y        = out_y_q;
	assign out_z        = out_z_q;
	assign out_w        = out_w_q;
	assign saturated    = saturated_q;

endmodule
